FILE: rtl/lfdc_pkg.sv
// ----------------------------------------------------------------------------
// lfdc_pkg: shared definitions for the line frequency and DC level meter
// Widths, register indexes, operation codes, sequencer states, divider
// status and the nibble rounding function used by the averaging path.
// ----------------------------------------------------------------------------
package lfdc_pkg;

	// Item field widths.
	localparam int OP_W     = 2;
	localparam int PERIOD_W = 16;
	localparam int PULSE_W  = 16;
	localparam int ADC_W    = 10;
	localparam int TEMP_W   = 9;
	localparam int VAL_W    = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DC_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_TO  = 2'd2;

	localparam logic [31:0] RATE_NUM_RST = 32'd62500000;
	localparam logic [15:0] DC_SCALE_RST = 16'd7250;
	localparam logic [15:0] LOSS_TO_RST  = 16'd10000;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_CAPTURE = 2'd0;
	localparam logic [OP_W-1:0] OP_WINDOW  = 2'd1;
	localparam logic [OP_W-1:0] OP_POLL    = 2'd2;

	// Averaging depths.
	localparam int FREQ_SAMPLES_DEF = 5;
	localparam int DC_SAMPLES_DEF   = 3;

	// Scaling constants: pulse*scale*5/100000 equals pulse*scale/20000.
	localparam logic [15:0] DC_DIVISOR   = 16'd20000;
	localparam logic [15:0] TEMP_FACTOR  = 16'd488;
	localparam logic [15:0] TEMP_DIVISOR = 16'd1000;

	// Shared divider geometry.
	localparam int DIV_DVD_W = 32;
	localparam int DIV_DVS_W = 16;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F_DIV,
		ST_F_ACC,
		ST_F_AVG,
		ST_D_MUL,
		ST_D_DIV,
		ST_D_AVG,
		ST_T_MUL,
		ST_T_DIV,
		ST_POLL,
		ST_FIN
	} lfdc_state_t;

	// Divider status seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} lfdc_div_stat_t;

	// Nibble rounding with 16-bit wrap on every sum.
	function automatic logic [VAL_W-1:0] nibble_round(input logic [VAL_W-1:0] x);
		logic [VAL_W-1:0] b;
		logic [VAL_W-1:0] d;
		logic [VAL_W-1:0] r;
		b = {12'd0, x[3:0]} - 16'd4;
		d = 16'd10 - b;
		if (b > 16'd5) begin
			r = x + {8'd0, d[7:0]};
		end else if (b < 16'd5) begin
			r = x - b;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

FILE: rtl/lfdc_if.sv
// ----------------------------------------------------------------------------
// lfdc_if: item channels of the line frequency and DC level meter
// A command channel carrying measurement events and a response channel
// carrying the held readings, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfdc_cmd_if;
	import lfdc_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [PERIOD_W-1:0] period_count;
	logic [PULSE_W-1:0]  pulse_count;
	logic [ADC_W-1:0]    adc_sample;

	modport source (output valid, operation, period_count, pulse_count, adc_sample,
		input ready);
	modport sink (input valid, operation, period_count, pulse_count, adc_sample,
		output ready);
endinterface

interface lfdc_rsp_if;
	import lfdc_pkg::*;

	logic              valid;
	logic              ready;
	logic [TEMP_W-1:0] temperature;
	logic [VAL_W-1:0]  line_freq;
	logic [VAL_W-1:0]  dc_latest;
	logic [VAL_W-1:0]  dc_average;

	modport source (output valid, temperature, line_freq, dc_latest, dc_average,
		input ready);
	modport sink (input valid, temperature, line_freq, dc_latest, dc_average,
		output ready);
endinterface

FILE: rtl/lfdc_div.sv
// ----------------------------------------------------------------------------
// lfdc_div: shared restoring divider
// Unsigned 32 by 16 bit division, one quotient bit per cycle. A start pulse
// loads the operands; done pulses as the last iteration is registered, and
// the quotient then holds until the next start.
// ----------------------------------------------------------------------------
module lfdc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lfdc_pkg::DIV_DVD_W-1:0]      dividend,
	input  logic [lfdc_pkg::DIV_DVS_W-1:0]      divisor,
	output lfdc_pkg::lfdc_div_stat_t            stat,
	output logic [lfdc_pkg::DIV_DVD_W-1:0]      quotient
);
	import lfdc_pkg::*;

	localparam int CNT_W = $clog2(DIV_DVD_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_DVS_W-1:0] rem_q;

	logic [DIV_DVS_W+1:0] diff;
	logic                 ge;
	logic [DIV_DVS_W-1:0] rem_next;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		diff = {1'b0, rem_q, dvd_q[DIV_DVD_W-1]} - {2'b00, dvs_q};
		ge = ~diff[DIV_DVS_W+1];
		rem_next = ge ? diff[DIV_DVS_W-1:0] : {rem_q[DIV_DVS_W-2:0], dvd_q[DIV_DVD_W-1]};
	end

	// Control: iteration counter, busy and done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits from the right.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

FILE: rtl/line_freq_and_dc_level_meter_unit.sv
// ----------------------------------------------------------------------------
// line_freq_and_dc_level_meter_unit: event-driven line frequency and DC meter
// Turns line period captures into a rounded average frequency, DC window
// pulse counts into a scaled and averaged voltage, and the converter sample
// into a temperature, using one multiplier and one serial divider.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Contents
//  -------  ---  -------------  ----------------------------------------------
//  cmd      in   valid/ready    operation, period_count, pulse_count, adc_sample
//  rsp      out  valid/ready    temperature, line_freq, dc_latest, dc_average
//  cfg      in   cfg_we         cfg_index, cfg_data (no read-back)
//
//  Each division on the shared divider runs 32 iterations. A capture with a
//  zero period skips the divider; one that completes a frequency set adds
//  the averaging division. A window close runs the DC and temperature
//  divisions, and the DC averaging division too when it completes a DC set.
//  A poll and an unused code skip the divider. cmd.ready is high only while
//  the sequencer is idle. A finished item waits in the response register,
//  and the next item is accepted meanwhile; its result is held back only
//  while the response register is still full. Reset is asynchronous and
//  takes effect at once; no clearing pass follows.
//
module line_freq_and_dc_level_meter_unit #(
	parameter int FREQ_SAMPLES = lfdc_pkg::FREQ_SAMPLES_DEF,
	parameter int DC_SAMPLES   = lfdc_pkg::DC_SAMPLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lfdc_cmd_if.sink                        cmd,
	lfdc_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [lfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfdc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lfdc_pkg::*;

	localparam int FIDX_W = $clog2(FREQ_SAMPLES);
	localparam int DIDX_W = $clog2(DC_SAMPLES);
	localparam int FSUM_W = VAL_W + FIDX_W;
	localparam int DSUM_W = VAL_W + DIDX_W;

	// Configuration registers.
	logic [31:0] rate_q;
	logic [15:0] scale_q;
	logic [15:0] timeout_q;

	// Captured item.
	logic [PERIOD_W-1:0] period_q;
	logic [PULSE_W-1:0]  pulse_q;
	logic [ADC_W-1:0]    adc_q;

	// Measurement state.
	logic [FSUM_W-1:0] fsum_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [DSUM_W-1:0] dsum_q;
	logic [DIDX_W-1:0] didx_q;
	logic [15:0]       idle_q;
	logic [VAL_W-1:0]  freq_q;
	logic [VAL_W-1:0]  dc_q;
	logic [VAL_W-1:0]  dcavg_q;
	logic [TEMP_W-1:0] temp_q;

	// Response register.
	logic              out_valid_q;
	logic [TEMP_W-1:0] out_temp_q;
	logic [VAL_W-1:0]  out_freq_q;
	logic [VAL_W-1:0]  out_dc_q;
	logic [VAL_W-1:0]  out_dcavg_q;

	// Shared multiplier product.
	logic [31:0] prod_q;

	lfdc_state_t state_q;
	lfdc_state_t state_d;

	logic                 cmd_acc;
	logic                 out_load;
	logic                 div_start;
	logic [DIV_DVD_W-1:0] div_dvd;
	logic [DIV_DVS_W-1:0] div_dvs;
	logic [DIV_DVD_W-1:0] div_quot;
	lfdc_div_stat_t       div_stat;
	logic [15:0]          mul_a;
	logic [15:0]          mul_b;
	logic [VAL_W-1:0]     quot_sat;
	logic [VAL_W-1:0]     f_val;
	logic                 fset_full;
	logic                 dset_full;

	lfdc_div u_lfdc_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Handshake and derived values.
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);
	assign quot_sat  = (div_quot[DIV_DVD_W-1:VAL_W] != '0) ? '1 : div_quot[VAL_W-1:0];
	assign f_val     = (period_q == '0) ? '0 : quot_sat;
	assign fset_full = (fidx_q == FIDX_W'(FREQ_SAMPLES - 1));
	assign dset_full = (didx_q == DIDX_W'(DC_SAMPLES - 1));

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					case (cmd.operation)
						OP_CAPTURE: state_d = (cmd.period_count == '0) ? ST_F_ACC : ST_F_DIV;
						OP_WINDOW:  state_d = ST_D_MUL;
						OP_POLL:    state_d = ST_POLL;
						default:    state_d = ST_FIN;
					endcase
				end
			end
			ST_F_DIV: if (div_stat.done) state_d = ST_F_ACC;
			ST_F_ACC: state_d = fset_full ? ST_F_AVG : ST_FIN;
			ST_F_AVG: if (div_stat.done) state_d = ST_FIN;
			ST_D_MUL: state_d = ST_D_DIV;
			ST_D_DIV: if (div_stat.done) state_d = dset_full ? ST_D_AVG : ST_T_MUL;
			ST_D_AVG: if (div_stat.done) state_d = ST_T_MUL;
			ST_T_MUL: state_d = ST_T_DIV;
			ST_T_DIV: if (div_stat.done) state_d = ST_FIN;
			ST_POLL:  state_d = ST_FIN;
			ST_FIN:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: ready, divider launch and operand selection.
	always_comb begin
		cmd.ready = 1'b0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		mul_a     = pulse_q;
		mul_b     = scale_q;
		unique case (state_q)
			ST_IDLE: cmd.ready = 1'b1;
			ST_F_DIV: begin
				div_dvd = rate_q;
				div_dvs = period_q;
			end
			ST_F_AVG: begin
				div_dvd = DIV_DVD_W'(fsum_q);
				div_dvs = DIV_DVS_W'(FREQ_SAMPLES);
			end
			ST_D_DIV: begin
				div_dvd = prod_q;
				div_dvs = DC_DIVISOR;
			end
			ST_D_AVG: begin
				div_dvd = DIV_DVD_W'(dsum_q);
				div_dvs = DIV_DVS_W'(DC_SAMPLES);
			end
			ST_T_MUL: begin
				mul_a = {6'd0, adc_q};
				mul_b = TEMP_FACTOR;
			end
			ST_T_DIV: begin
				div_dvd = prod_q;
				div_dvs = TEMP_DIVISOR;
			end
			default: ;
		endcase
		if ((state_q == ST_F_DIV || state_q == ST_F_AVG || state_q == ST_D_DIV ||
			state_q == ST_D_AVG || state_q == ST_T_DIV) &&
			!div_stat.busy && !div_stat.done) begin
			div_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= RATE_NUM_RST;
			scale_q   <= DC_SCALE_RST;
			timeout_q <= LOSS_TO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATE_NUM: rate_q    <= cfg_data;
				REG_DC_SCALE: scale_q   <= cfg_data[15:0];
				REG_LOSS_TO:  timeout_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Item capture and the shared multiplier.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			period_q <= cmd.period_count;
			pulse_q  <= cmd.pulse_count;
			adc_q    <= cmd.adc_sample;
		end
		if (state_q == ST_D_MUL || state_q == ST_T_MUL) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Frequency, DC and temperature state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsum_q  <= '0;
			fidx_q  <= '0;
			dsum_q  <= '0;
			didx_q  <= '0;
			idle_q  <= '0;
			freq_q  <= '0;
			dc_q    <= '0;
			dcavg_q <= '0;
			temp_q  <= '0;
		end else begin
			case (state_q)
				ST_F_ACC: begin
					idle_q <= '0;
					fsum_q <= fsum_q + FSUM_W'(f_val);
					fidx_q <= fset_full ? '0 : fidx_q + 1'b1;
				end
				ST_F_AVG: begin
					if (div_stat.done) begin
						freq_q <= nibble_round(div_quot[VAL_W-1:0]);
						fsum_q <= '0;
					end
				end
				ST_D_DIV: begin
					if (div_stat.done) begin
						dc_q   <= quot_sat;
						dsum_q <= dsum_q + DSUM_W'(quot_sat);
						didx_q <= dset_full ? '0 : didx_q + 1'b1;
					end
				end
				ST_D_AVG: begin
					if (div_stat.done) begin
						dcavg_q <= div_quot[VAL_W-1:0];
						dsum_q  <= '0;
					end
				end
				ST_T_DIV: begin
					if (div_stat.done) begin
						temp_q <= div_quot[TEMP_W-1:0];
					end
				end
				ST_POLL: begin
					if (idle_q >= timeout_q) begin
						freq_q <= '0;
					end else begin
						idle_q <= idle_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Response register: loaded from the held values when an item finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_temp_q  <= temp_q;
			out_freq_q  <= freq_q;
			out_dc_q    <= dc_q;
			out_dcavg_q <= dcavg_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.temperature = out_temp_q;
	assign rsp.line_freq   = out_freq_q;
	assign rsp.dc_latest   = out_dc_q;
	assign rsp.dc_average  = out_dcavg_q;

endmodule

FILE: rtl/lfdc_checker.sv
// ----------------------------------------------------------------------------
// lfdc_checker: port-level checks for the meter
// Watches the command and response channels of the top level and flags
// handshake and sequencing slips.
// ----------------------------------------------------------------------------
module lfdc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [lfdc_pkg::TEMP_W-1:0]   temperature,
	input logic [lfdc_pkg::VAL_W-1:0]    line_freq,
	input logic [lfdc_pkg::VAL_W-1:0]    dc_latest,
	input logic [lfdc_pkg::VAL_W-1:0]    dc_average
);
	import lfdc_pkg::*;

	// A stalled response item keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(temperature) &&
		$stable(line_freq) && $stable(dc_latest) && $stable(dc_average))
		else $error("stalled response item changed");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while an item was in progress");

	// A new response appears exactly as the sequencer returns to idle.
	a_rsp_rise_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> cmd_ready)
		else $error("response appeared while the sequencer was busy");

	// The temperature scaling never exceeds its full-scale reading.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> temperature <= 9'd499)
		else $error("temperature out of range");

endmodule

bind line_freq_and_dc_level_meter_unit lfdc_checker u_lfdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.temperature (rsp.temperature),
	.line_freq   (rsp.line_freq),
	.dc_latest   (rsp.dc_latest),
	.dc_average  (rsp.dc_average)
);

FILE: test/tb_line_freq_and_dc_level_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_freq_and_dc_level_meter_unit: self-checking bench for the meter
// Drives capture, window, poll and unused events through the command channel
// under several register settings and idle patterns. A cycle-free predictor
// computes the held readings for every accepted item, and each response is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_line_freq_and_dc_level_meter_unit;
	import lfdc_pkg::*;

	// The fourth operation code is not decoded by the block.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int N_FREQ = FREQ_SAMPLES_DEF;
	localparam int N_DC   = DC_SAMPLES_DEF;

	localparam logic [63:0] DC_MULT     = 64'd5;
	localparam logic [63:0] DC_DIV      = 64'd100000;
	localparam logic [31:0] TEMP_MULT   = 32'd488;
	localparam logic [31:0] TEMP_DIV    = 32'd1000;
	localparam logic [31:0] FREQ_CEIL   = 32'h0000_FFFF;
	localparam int          QUIET_LIMIT = 4000;
	localparam int          TAIL_CYCLES = 150;
	localparam int          PHASE_ITEMS = 168;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [PERIOD_W-1:0] period_count;
		logic [PULSE_W-1:0]  pulse_count;
		logic [ADC_W-1:0]    adc_sample;
	} meter_event_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature;
		logic [VAL_W-1:0]  line_freq;
		logic [VAL_W-1:0]  dc_latest;
		logic [VAL_W-1:0]  dc_average;
	} meter_reading_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lfdc_cmd_if cmd_ch ();
	lfdc_rsp_if rsp_ch ();

	line_freq_and_dc_level_meter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies and measurement state of the predictor.
	logic [31:0]      rate_num_q;
	logic [15:0]      dc_scale_q;
	logic [15:0]      loss_to_q;
	logic [VAL_W-1:0] freq_hist [N_FREQ];
	logic [VAL_W-1:0] dc_hist [N_DC];
	int               freq_fill;
	int               dc_fill;
	logic [15:0]      idle_polls;
	logic [VAL_W-1:0] freq_out;
	logic [VAL_W-1:0] dc_out;
	logic [VAL_W-1:0] dc_avg_out;
	logic [TEMP_W-1:0] temp_out;

	meter_event_t   pending_events[$];
	meter_reading_t expected_readings[$];
	int             queued_total;
	int             accepted_total;
	int             fail_count;
	int             quiet_cycles;
	int             send_idle_pct;
	int             stall_pct;
	logic           cmd_fire;

	// Rounding of the averaged frequency, worked out per low nibble.
	// Nibbles 4 to 8 step down to 4, nibble 9 stays, all others add
	// (14 - nibble) taken modulo 256, with a 16-bit wrap on the sum.
	function automatic logic [VAL_W-1:0] round_nibble(input logic [VAL_W-1:0] x);
		logic [3:0] low;
		logic [7:0] step;
		low = x[3:0];
		step = 8'd14 - {4'd0, low};
		if (low == 4'd9)
			return x;
		else if (low >= 4'd4 && low <= 4'd8)
			return x - {12'd0, low - 4'd4};
		else
			return x + {8'd0, step};
	endfunction

	// Applies one accepted event to the predicted state and returns the
	// readings the block must report for it.
	function meter_reading_t apply_event(input meter_event_t ev);
		logic [31:0]    quot;
		logic [31:0]    sum;
		logic [31:0]    mean;
		logic [63:0]    dc_full;
		logic [31:0]    temp_full;
		meter_reading_t r;
		case (ev.operation)
			OP_CAPTURE: begin
				quot = 32'd0;
				if (ev.period_count != '0) begin
					quot = rate_num_q / {16'd0, ev.period_count};
					if (quot > FREQ_CEIL)
						quot = FREQ_CEIL;
				end
				freq_hist[freq_fill] = quot[15:0];
				freq_fill++;
				idle_polls = '0;
				if (freq_fill == N_FREQ) begin
					sum = '0;
					for (int k = 0; k < N_FREQ; k++)
						sum += {16'd0, freq_hist[k]};
					mean = sum / N_FREQ;
					freq_out = round_nibble(mean[15:0]);
					freq_fill = 0;
				end
			end
			OP_WINDOW: begin
				dc_full = {48'd0, ev.pulse_count} * {48'd0, dc_scale_q} * DC_MULT / DC_DIV;
				if (dc_full > 64'h0000_0000_0000_FFFF)
					dc_full = 64'h0000_0000_0000_FFFF;
				dc_out = dc_full[15:0];
				dc_hist[dc_fill] = dc_out;
				dc_fill++;
				if (dc_fill == N_DC) begin
					sum = '0;
					for (int k = 0; k < N_DC; k++)
						sum += {16'd0, dc_hist[k]};
					mean = sum / N_DC;
					dc_avg_out = mean[15:0];
					dc_fill = 0;
				end
				temp_full = ({22'd0, ev.adc_sample} * TEMP_MULT) / TEMP_DIV;
				temp_out = temp_full[TEMP_W-1:0];
			end
			OP_POLL: begin
				if (idle_polls >= loss_to_q)
					freq_out = '0;
				else
					idle_polls = idle_polls + 16'd1;
			end
			default: begin
			end
		endcase
		r.temperature = temp_out;
		r.line_freq   = freq_out;
		r.dc_latest   = dc_out;
		r.dc_average  = dc_avg_out;
		return r;
	endfunction

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Command driver and response stall pattern, both updated on the falling edge.
	always @(negedge clk) begin
		meter_event_t next_ev;
		if (arst_n) begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			if (!cmd_ch.valid || cmd_fire) begin
				if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_ev = pending_events.pop_front();
					cmd_ch.operation    <= next_ev.operation;
					cmd_ch.period_count <= next_ev.period_count;
					cmd_ch.pulse_count  <= next_ev.pulse_count;
					cmd_ch.adc_sample   <= next_ev.adc_sample;
					cmd_ch.valid        <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts on every accepted item, checks every accepted response
	// and watches for a stalled handshake.
	always @(posedge clk) begin
		meter_event_t   seen_ev;
		meter_reading_t want;
		if (arst_n) begin
			cmd_fire <= cmd_ch.valid && cmd_ch.ready;

			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_readings.size() == 0) begin
					$error("response item arrived with no prediction outstanding");
					fail_count++;
				end else begin
					want = expected_readings.pop_front();
					if (rsp_ch.temperature !== want.temperature) begin
						$error("temperature: expected %0d, got %0d", want.temperature,
							rsp_ch.temperature);
						fail_count++;
					end
					if (rsp_ch.line_freq !== want.line_freq) begin
						$error("line_freq: expected %0d, got %0d", want.line_freq,
							rsp_ch.line_freq);
						fail_count++;
					end
					if (rsp_ch.dc_latest !== want.dc_latest) begin
						$error("dc_latest: expected %0d, got %0d", want.dc_latest,
							rsp_ch.dc_latest);
						fail_count++;
					end
					if (rsp_ch.dc_average !== want.dc_average) begin
						$error("dc_average: expected %0d, got %0d", want.dc_average,
							rsp_ch.dc_average);
						fail_count++;
					end
				end
			end

			if (cmd_ch.valid && cmd_ch.ready) begin
				seen_ev.operation    = cmd_ch.operation;
				seen_ev.period_count = cmd_ch.period_count;
				seen_ev.pulse_count  = cmd_ch.pulse_count;
				seen_ev.adc_sample   = cmd_ch.adc_sample;
				expected_readings.push_back(apply_event(seen_ev));
				accepted_total++;
			end

			// Watchdog on cycles without any handshake.
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	// Register write, mirrored into the predictor's copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_RATE_NUM: rate_num_q = val;
			REG_DC_SCALE: dc_scale_q = val[15:0];
			REG_LOSS_TO:  loss_to_q = val[15:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_event(input logic [OP_W-1:0] op, input logic [15:0] period,
		input logic [15:0] pulse, input logic [ADC_W-1:0] adc);
		meter_event_t ev;
		ev.operation    = op;
		ev.period_count = period;
		ev.pulse_count  = pulse;
		ev.adc_sample   = adc;
		pending_events.push_back(ev);
		queued_total++;
	endtask

	// Blocks until every queued item is accepted and answered.
	task automatic drain;
		while (accepted_total != queued_total || expected_readings.size() != 0)
			@(negedge clk);
	endtask

	// Periods near a real line and fully random ones in equal shares, with tiny and extreme ones.
	function automatic logic [15:0] pick_period();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return 16'($urandom_range(15));
		else if (sel <= 4)
			return 16'($urandom_range(1200, 900));
		else if (sel == 5)
			return ($urandom_range(1) == 1) ? 16'hFFFF : 16'd1;
		else
			return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_pulse();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return ($urandom_range(1) == 1) ? 16'hFFFF : 16'd0;
		else if (sel <= 2)
			return 16'($urandom_range(2000));
		else
			return 16'($urandom);
	endfunction

	// One burst of events: mostly complete capture and window sets and poll
	// runs long enough to hit a short timeout, with some broken sets and
	// unused codes mixed in.
	task automatic add_burst(output int added);
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 45) begin
			n = ($urandom_range(3) == 0) ? $urandom_range(7, 1) : N_FREQ;
			for (int k = 0; k < n; k++)
				queue_event(OP_CAPTURE, pick_period(), 16'($urandom), 10'($urandom));
		end else if (kind < 75) begin
			n = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : N_DC;
			for (int k = 0; k < n; k++)
				queue_event(OP_WINDOW, 16'($urandom), pick_pulse(), 10'($urandom));
		end else if (kind < 95) begin
			n = ($urandom_range(4) == 0) ? $urandom_range(40, 10) : $urandom_range(4, 1);
			for (int k = 0; k < n; k++)
				queue_event(OP_POLL, 16'($urandom), 16'($urandom), 10'($urandom));
		end else begin
			n = 1;
			queue_event(OP_UNUSED, 16'($urandom), 16'($urandom), 10'($urandom));
		end
		added = n;
	endtask

	// Main sequence: reset, directed checks, then random phases.
	initial begin
		int added;
		int count;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.operation    = OP_POLL;
		cmd_ch.period_count = '0;
		cmd_ch.pulse_count  = '0;
		cmd_ch.adc_sample   = '0;
		rsp_ch.ready        = 1'b0;
		cmd_fire            = 1'b0;
		rate_num_q          = RATE_NUM_RST;
		dc_scale_q          = DC_SCALE_RST;
		loss_to_q           = LOSS_TO_RST;
		freq_fill           = 0;
		dc_fill             = 0;
		idle_polls          = '0;
		freq_out            = '0;
		dc_out              = '0;
		dc_avg_out          = '0;
		temp_out            = '0;
		queued_total        = 0;
		accepted_total      = 0;
		fail_count          = 0;
		quiet_cycles        = 0;
		send_idle_pct       = 0;
		stall_pct           = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: saturating, zero and line-like periods completing a
		// frequency set, extreme windows completing a dc set, a poll and an
		// unused code.
		queue_event(OP_CAPTURE, 16'd1, 16'd0, 10'd0);
		queue_event(OP_CAPTURE, 16'd0, 16'd0, 10'd0);
		queue_event(OP_CAPTURE, 16'hFFFF, 16'd0, 10'd0);
		queue_event(OP_CAPTURE, 16'd1041, 16'd0, 10'd0);
		queue_event(OP_CAPTURE, 16'd1042, 16'd0, 10'd0);
		queue_event(OP_WINDOW, 16'd0, 16'd0, 10'd0);
		queue_event(OP_WINDOW, 16'hFFFF, 16'hFFFF, 10'h3FF);
		queue_event(OP_WINDOW, 16'd0, 16'd1234, 10'd512);
		queue_event(OP_POLL, 16'd0, 16'd0, 10'd0);
		queue_event(OP_UNUSED, 16'hFFFF, 16'hFFFF, 10'h3FF);
		drain();

		// Zero rate, largest dc scale, zero timeout.
		write_reg(REG_RATE_NUM, 32'd0);
		write_reg(REG_DC_SCALE, 32'h0000_FFFF);
		write_reg(REG_LOSS_TO, 32'd0);
		queue_event(OP_WINDOW, 16'd0, 16'hFFFF, 10'h3FF);
		queue_event(OP_CAPTURE, 16'd1, 16'd0, 10'd0);
		queue_event(OP_CAPTURE, 16'd2, 16'd0, 10'd0);
		queue_event(OP_CAPTURE, 16'd3, 16'd0, 10'd0);
		queue_event(OP_CAPTURE, 16'hFFFF, 16'd0, 10'd0);
		queue_event(OP_CAPTURE, 16'd0, 16'd0, 10'd0);
		queue_event(OP_POLL, 16'd0, 16'd0, 10'd0);
		drain();

		// Largest rate, zero dc scale, short timeout reached by polls.
		write_reg(REG_RATE_NUM, 32'hFFFF_FFFF);
		write_reg(REG_DC_SCALE, 32'd0);
		write_reg(REG_LOSS_TO, 32'd2);
		for (int k = 0; k < N_FREQ; k++)
			queue_event(OP_CAPTURE, 16'hFFFF, 16'd0, 10'd0);
		queue_event(OP_WINDOW, 16'd0, 16'hFFFF, 10'd0);
		for (int k = 0; k < 4; k++)
			queue_event(OP_POLL, 16'd0, 16'd0, 10'd0);
		drain();

		// Random phases, each with its own settings and idle pattern.
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: write_reg(REG_RATE_NUM, RATE_NUM_RST);
				1: write_reg(REG_RATE_NUM, 32'd1);
				2: write_reg(REG_RATE_NUM, 32'hFFFF_FFFF);
				default: write_reg(REG_RATE_NUM, $urandom);
			endcase
			case ((p + 1) % 4)
				0: write_reg(REG_DC_SCALE, 32'd0);
				1: write_reg(REG_DC_SCALE, 32'h0000_FFFF);
				2: write_reg(REG_DC_SCALE, {16'd0, DC_SCALE_RST});
				default: write_reg(REG_DC_SCALE, {16'd0, 16'($urandom)});
			endcase
			case ((p + 2) % 4)
				0: write_reg(REG_LOSS_TO, 32'd1);
				1: write_reg(REG_LOSS_TO, 32'h0000_FFFF);
				2: write_reg(REG_LOSS_TO, 32'($urandom_range(30, 1)));
				default: write_reg(REG_LOSS_TO, 32'($urandom_range(12, 2)));
			endcase
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 64;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 64;
				end
				default: begin
					send_idle_pct = 6;
					stall_pct     = 6;
				end
			endcase
			count = 0;
			while (count < PHASE_ITEMS) begin
				add_burst(added);
				count += added;
			end
			drain();
		end

		// Let any stray response show up before the verdict.
		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_readings.size() != 0) begin
			$error("%0d predicted responses never arrived", expected_readings.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
